### sv/sar_pkg.sv
// Package for the screen attribute renderer: store geometry, action codes,
// sequencer states and the palette function. No dependencies.
package sar_pkg;

    localparam int BMP_DEPTH  = 6144;
    localparam int ATTR_DEPTH = 768;
    localparam int BMP_AW     = $clog2(BMP_DEPTH);
    localparam int ATTR_AW    = $clog2(ATTR_DEPTH);
    localparam int RUN_LEN    = 8;
    localparam int RUN_CW     = $clog2(RUN_LEN);

    localparam logic [5:0] FLASH_PERIOD_RST = 6'd13;
    localparam logic [7:0] LEVEL_NORMAL     = 8'd200;
    localparam logic [7:0] LEVEL_BRIGHT     = 8'd255;

    typedef enum logic [1:0] {
        ACT_WRITE  = 2'd0,
        ACT_TICK   = 2'd1,
        ACT_RENDER = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_RD    = 5'b00100,
        S_WAIT  = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    // Palette: bit 3 bright, bit 2 green, bit 1 red, bit 0 blue.
    function automatic logic [23:0] color_rgb(input logic [3:0] idx);
        logic [7:0] lvl;
        lvl = idx[3] ? LEVEL_BRIGHT : LEVEL_NORMAL;
        return {idx[1] ? lvl : 8'd0, idx[2] ? lvl : 8'd0, idx[0] ? lvl : 8'd0};
    endfunction

endpackage

### sv/sar_ram.sv
// Generic single-port synchronous RAM with a registered read (read-first).
// No dependencies.
module sar_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/screen_attribute_renderer_core.sv
// Screen attribute renderer core: bitmap and attribute RAMs plus a redraw sequencer.
// Requests are taken only in S_IDLE; a redraw passes through S_RD and S_WAIT to
// S_OUT, and each further row of an attribute run goes through S_RD and S_WAIT again.
// A new request waits until the last result of the one before is taken; a tick leaves
// the sequencer idle. Each store has a single RAM port.
// Reset: synchronous, active low; a clearing pass then zeroes both stores.
module screen_attribute_renderer_core
    import sar_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request channel.
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_action,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_data,
    // Result channel.
    output logic        o_valid,
    input  logic        i_ready,
    output logic [4:0]  o_column,
    output logic [7:0]  o_line,
    output logic [7:0]  o_pattern,
    output logic [3:0]  o_fg_color,
    output logic [3:0]  o_bg_color,
    output logic [23:0] o_fg_rgb,
    output logic [23:0] o_bg_rgb,
    output logic        o_last,
    // Flash period register.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [5:0]  i_cfg_data
);

    t_state r_state, n_state;

    logic [BMP_AW-1:0] r_clr;     // clearing pass address
    logic [BMP_AW-1:0] r_off;     // bitmap offset of the byte being redrawn
    logic              r_multi;   // attribute run of eight rows
    logic [RUN_CW-1:0] r_cnt;     // row within the run
    logic [5:0]        r_flash_cnt;
    logic              r_flash_inv;
    logic [5:0]        r_flash_period;

    logic [4:0]  r_column;
    logic [7:0]  r_line;
    logic [7:0]  r_pattern;
    logic [3:0]  r_fg, r_bg;
    logic [23:0] r_fg_rgb, r_bg_rgb;
    logic        r_last;

    logic               bm_we, at_we;
    logic [BMP_AW-1:0]  bm_addr;
    logic [ATTR_AW-1:0] at_addr;
    logic [7:0]         bm_wdata, at_wdata, bm_rdata, at_rdata;

    t_action act;
    logic    acc;
    logic    in_bmp_ok, in_att_ok;
    logic [5:0] flash_inc;
    logic [3:0] ink, paper, fg, bg;
    logic       clr_done;

    assign act = t_action'(i_action);
    assign acc = i_valid && o_ready;

    // Bitmap lives at 0x4000..0x57FF, attributes at 0x5800..0x5AFF.
    assign in_bmp_ok = (i_address[15:13] == 3'b010) && (i_address[12:11] != 2'b11);
    assign in_att_ok = (i_address[15:10] == 6'b010110) && (i_address[9:8] != 2'b11);

    assign clr_done  = (r_clr == BMP_AW'(BMP_DEPTH - 1));
    assign flash_inc = r_flash_cnt + 6'd1;

    // Colour rule: bright raises both indices, flash swaps them while inverted.
    assign ink   = {at_rdata[6], at_rdata[2:0]};
    assign paper = {at_rdata[6], at_rdata[5:3]};
    assign fg    = (at_rdata[7] && r_flash_inv) ? paper : ink;
    assign bg    = (at_rdata[7] && r_flash_inv) ? ink : paper;

    // RAM port steering: the clearing pass, a store write at acceptance, or the
    // redraw read. Only one of these can happen in any state, so no collision.
    always_comb begin
        bm_we    = 1'b0;
        at_we    = 1'b0;
        bm_addr  = r_off;
        at_addr  = {r_off[12:11], r_off[7:0]};
        bm_wdata = i_data;
        at_wdata = i_data;
        case (r_state)
            S_CLEAR: begin
                bm_we    = 1'b1;
                at_we    = (r_clr < BMP_AW'(ATTR_DEPTH));
                bm_addr  = r_clr;
                at_addr  = r_clr[ATTR_AW-1:0];
                bm_wdata = 8'd0;
                at_wdata = 8'd0;
            end
            S_IDLE: begin
                if (acc && act == ACT_WRITE) begin
                    bm_we   = in_bmp_ok;
                    at_we   = in_att_ok;
                    bm_addr = i_address[BMP_AW-1:0];
                    at_addr = i_address[ATTR_AW-1:0];
                end
            end
            default: ;
        endcase
    end

    sar_ram #(.WIDTH(8), .DEPTH(BMP_DEPTH)) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (bm_we),
        .i_addr  (bm_addr),
        .i_wdata (bm_wdata),
        .o_rdata (bm_rdata)
    );

    sar_ram #(.WIDTH(8), .DEPTH(ATTR_DEPTH)) u_attr (
        .i_clk   (i_clk),
        .i_we    (at_we),
        .i_addr  (at_addr),
        .i_wdata (at_wdata),
        .o_rdata (at_rdata)
    );

    // Sequencer. A redraw reads both stores in S_RD, the data returns in S_WAIT
    // and is registered into the result, which is held in S_OUT until taken.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (acc) begin
                    if ((act == ACT_WRITE && (in_bmp_ok || in_att_ok)) ||
                        (act == ACT_RENDER && in_bmp_ok)) begin
                        n_state = S_RD;
                    end
                end
            end
            S_RD:   n_state = S_WAIT;
            S_WAIT: n_state = S_OUT;
            S_OUT: begin
                if (i_ready) n_state = r_last ? S_IDLE : S_RD;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLEAR;
            r_clr          <= '0;
            r_flash_cnt    <= '0;
            r_flash_inv    <= 1'b0;
            r_flash_period <= FLASH_PERIOD_RST;
            r_multi        <= 1'b0;
            r_cnt          <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_flash_period <= i_cfg_data;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + BMP_AW'(1);
                end
                S_IDLE: begin
                    if (acc) begin
                        r_cnt <= '0;
                        case (act)
                            ACT_WRITE: begin
                                r_multi <= !in_bmp_ok;
                                if (in_bmp_ok) begin
                                    r_off <= i_address[BMP_AW-1:0];
                                end else begin
                                    // First row of the cell: third, row zero, char row, column.
                                    r_off <= {i_address[9:8], 3'b000, i_address[7:0]};
                                end
                            end
                            ACT_TICK: begin
                                if (flash_inc >= r_flash_period) begin
                                    r_flash_cnt <= '0;
                                    r_flash_inv <= !r_flash_inv;
                                end else begin
                                    r_flash_cnt <= flash_inc;
                                end
                            end
                            ACT_RENDER: begin
                                r_multi <= 1'b0;
                                r_off   <= i_address[BMP_AW-1:0];
                            end
                            default: ;
                        endcase
                    end
                end
                S_OUT: begin
                    if (i_ready && !r_last) begin
                        // Next pixel row of the same cell lies 256 bytes on.
                        r_off <= r_off + BMP_AW'(256);
                        r_cnt <= r_cnt + RUN_CW'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // Result registers, loaded when the read data returns.
    always_ff @(posedge i_clk) begin
        if (r_state == S_WAIT) begin
            r_column  <= r_off[4:0];
            r_line    <= {r_off[12:11], r_off[7:5], r_off[10:8]};
            r_pattern <= bm_rdata;
            r_fg      <= fg;
            r_bg      <= bg;
            r_fg_rgb  <= color_rgb(fg);
            r_bg_rgb  <= color_rgb(bg);
            r_last    <= !r_multi || (r_cnt == RUN_CW'(RUN_LEN - 1));
        end
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_valid     = (r_state == S_OUT);
    assign o_cfg_ready = 1'b1;
    assign o_column    = r_column;
    assign o_line      = r_line;
    assign o_pattern   = r_pattern;
    assign o_fg_color  = r_fg;
    assign o_bg_color  = r_bg;
    assign o_fg_rgb    = r_fg_rgb;
    assign o_bg_rgb    = r_bg_rgb;
    assign o_last      = r_last;

`ifndef SYNTHESIS
    // No request is taken during the clearing pass.
    a_no_req_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_ready)
        else $error("request taken during clearing pass");

    // Requests and results never overlap.
    a_req_excl_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |-> !o_valid)
        else $error("request accepted while a result is pending");

    // Within a run, the next result follows after the read turnaround.
    a_run_timing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !o_last) |=> !o_valid ##1 !o_valid ##1 o_valid)
        else $error("attribute run result timing broken");

    // Rows of an attribute run are consecutive lines.
    a_run_lines: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !o_last) |-> ##3 (o_line == 8'($past(o_line, 3) + 8'd1)))
        else $error("attribute run lines not consecutive");
`endif

endmodule

### tb/sv/screen_attribute_renderer_core_test.sv
// Self-checking testbench for screen_attribute_renderer_core: directed and random
// requests, with redraws predicted from a local copy of the display store.
// Depends on sar_pkg and the core itself.
`timescale 1ns / 1ps

module screen_attribute_renderer_core_test;
    import sar_pkg::*;

    // Memory map of the display, as seen on the request address.
    localparam logic [15:0] VIDEO_BASE = 16'd16384;
    localparam logic [15:0] ATTR_BASE  = 16'd22528;
    localparam logic [15:0] ATTR_END   = 16'd23296;

    // The clearing pass after reset keeps the request and result channels closed,
    // so the watchdog limit sits well above its length.
    localparam int STALL_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 32;

    // One redrawn bitmap byte, as the result channel reports it.
    typedef struct packed {
        logic [4:0]  column;
        logic [7:0]  line;
        logic [7:0]  pattern;
        logic [3:0]  fg_color;
        logic [3:0]  bg_color;
        logic [23:0] fg_rgb;
        logic [23:0] bg_rgb;
        logic        last;
    } t_redraw;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic        o_ready;
    t_action     req_action  = ACT_NONE;
    logic [15:0] req_address = 16'd0;
    logic [7:0]  req_data    = 8'd0;
    logic        o_valid;
    logic        i_ready     = 1'b0;
    logic [4:0]  o_column;
    logic [7:0]  o_line;
    logic [7:0]  o_pattern;
    logic [3:0]  o_fg_color;
    logic [3:0]  o_bg_color;
    logic [23:0] o_fg_rgb;
    logic [23:0] o_bg_rgb;
    logic        o_last;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [5:0]  i_cfg_data  = FLASH_PERIOD_RST;

    // Local copy of the block state: display store, flash counter and period.
    logic [7:0]  screen_mem [0:BMP_DEPTH+ATTR_DEPTH-1];
    logic [5:0]  blink_count;
    logic        blink_inverted;
    logic [5:0]  blink_period;

    t_redraw     pending_redraws [$];
    int          mismatch_count = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    bit          last_request_acted;

    // A few screen cells that most random traffic is steered to, so that
    // bitmap writes, attribute writes and renders meet on the same bytes.
    int          focus_line [4];
    int          focus_col  [4];

    screen_attribute_renderer_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_action    (req_action),
        .i_address   (req_address),
        .i_data      (req_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_column    (o_column),
        .o_line      (o_line),
        .o_pattern   (o_pattern),
        .o_fg_color  (o_fg_color),
        .o_bg_color  (o_bg_color),
        .o_fg_rgb    (o_fg_rgb),
        .o_bg_rgb    (o_bg_rgb),
        .o_last      (o_last),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Palette: bit 3 selects the bright level, bits 1, 2 and 0 light red,
    // green and blue.
    function automatic logic [23:0] palette_rgb(input logic [3:0] color);
        logic [7:0] level;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        level = color[3] ? 8'd255 : 8'd200;
        red   = color[1] ? level : 8'd0;
        green = color[2] ? level : 8'd0;
        blue  = color[0] ? level : 8'd0;
        return {red, green, blue};
    endfunction

    // Redraw of the bitmap byte at the given store offset. The offset packs
    // the screen third, pixel row, character row and column, in that order
    // from the top; the attribute cell is found from the resulting line.
    function automatic t_redraw redraw_of(input int unsigned offset, input logic last);
        t_redraw     r;
        int unsigned line_no;
        int unsigned col;
        logic [7:0]  attr;
        logic [3:0]  ink;
        logic [3:0]  paper;
        col     = offset & 31;
        line_no = ((offset >> 11) & 3) * 64 + ((offset >> 5) & 7) * 8 + ((offset >> 8) & 7);
        attr    = screen_mem[BMP_DEPTH + (line_no >> 3) * 32 + col];
        // Bright lifts ink and paper into the upper half of the palette.
        ink     = {attr[6], attr[2:0]};
        paper   = {attr[6], attr[5:3]};
        r.column  = 5'(col);
        r.line    = 8'(line_no);
        r.pattern = screen_mem[offset];
        // Flash swaps ink and paper only while the inversion is active.
        if (attr[7] && blink_inverted) begin
            r.fg_color = paper;
            r.bg_color = ink;
        end else begin
            r.fg_color = ink;
            r.bg_color = paper;
        end
        r.fg_rgb = palette_rgb(r.fg_color);
        r.bg_rgb = palette_rgb(r.bg_color);
        r.last   = last;
        return r;
    endfunction

    // Applies one accepted request to the local state and queues the
    // redraws it must cause. Returns 0 for requests the block ignores.
    function automatic bit predict_redraws(input t_action act, input logic [15:0] addr,
                                           input logic [7:0] dat);
        int unsigned attr_cell;
        int unsigned base;
        int          row;
        bit          acted;
        acted = 1'b0;
        case (act)
            ACT_TICK: begin
                acted = 1'b1;
                blink_count = blink_count + 6'd1;
                // A period of zero is already reached after one tick.
                if (blink_count >= blink_period) begin
                    blink_count    = 6'd0;
                    blink_inverted = ~blink_inverted;
                end
            end
            ACT_WRITE: begin
                if (addr >= VIDEO_BASE && addr < ATTR_END) begin
                    acted = 1'b1;
                    screen_mem[addr - VIDEO_BASE] = dat;
                    if (addr < ATTR_BASE) begin
                        pending_redraws.push_back(redraw_of(addr - VIDEO_BASE, 1'b1));
                    end else begin
                        // An attribute cell covers eight bitmap bytes, one per
                        // pixel row, spaced 256 bytes apart.
                        attr_cell = addr - ATTR_BASE;
                        base = ((attr_cell >> 8) << 11) + (attr_cell & 255);
                        for (row = 0; row < 8; row++) begin
                            pending_redraws.push_back(redraw_of(base + (row << 8), row == 7));
                        end
                    end
                end
            end
            ACT_RENDER: begin
                // Render of an attribute address gives nothing.
                if (addr >= VIDEO_BASE && addr < ATTR_BASE) begin
                    acted = 1'b1;
                    pending_redraws.push_back(redraw_of(addr - VIDEO_BASE, 1'b1));
                end
            end
            default: begin
            end
        endcase
        return acted;
    endfunction

    function automatic logic [15:0] bitmap_address(input int line_no, input int col);
        return 16'(VIDEO_BASE + ((line_no >> 6) << 11) + ((line_no & 7) << 8)
                   + (((line_no >> 3) & 7) << 5) + col);
    endfunction

    function automatic logic [15:0] attribute_address(input int line_no, input int col);
        return 16'(ATTR_BASE + (line_no >> 3) * 32 + col);
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < 50) begin
            $display("%0t ns: %s", $realtime, msg);
        end
        mismatch_count++;
    endtask

    // Sends one request. Valid is only dropped when an idle gap is taken, so a
    // request that follows at once keeps valid high without a glitch.
    task automatic send_request(input t_action act, input logic [15:0] addr,
                                input logic [7:0] dat);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_valid     <= 1'b1;
        req_action  <= act;
        req_address <= addr;
        req_data    <= dat;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        last_request_acted = predict_redraws(act, addr, dat);
    endtask

    // Closes the request channel, waits for every redraw, then gives the
    // block time to finish requests that produce no result.
    task automatic settle_block();
        i_valid <= 1'b0;
        while (pending_redraws.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_flash_period(input logic [5:0] period);
        settle_block();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= period;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        blink_period = period;
        i_cfg_valid <= 1'b0;
    endtask

    // The receiver stalls at random in every cycle, at the current rate.
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Each taken result is compared field by field with the oldest redraw
    // still waiting.
    always @(posedge i_clk) begin
        t_redraw want;
        if (i_rst_n && o_valid === 1'b1 && i_ready) begin
            if (pending_redraws.size() == 0) begin
                report_mismatch($sformatf("unexpected result at column %0d line %0d",
                                          o_column, o_line));
            end else begin
                want = pending_redraws.pop_front();
                if (o_column !== want.column)
                    report_mismatch($sformatf("column: got %0d, expected %0d",
                                              o_column, want.column));
                if (o_line !== want.line)
                    report_mismatch($sformatf("line: got %0d, expected %0d",
                                              o_line, want.line));
                if (o_pattern !== want.pattern)
                    report_mismatch($sformatf("pattern at line %0d column %0d: got %h, expected %h",
                                              want.line, want.column, o_pattern, want.pattern));
                if (o_fg_color !== want.fg_color)
                    report_mismatch($sformatf("ink at line %0d column %0d: got %0d, expected %0d",
                                              want.line, want.column, o_fg_color, want.fg_color));
                if (o_bg_color !== want.bg_color)
                    report_mismatch($sformatf("paper at line %0d column %0d: got %0d, expected %0d",
                                              want.line, want.column, o_bg_color, want.bg_color));
                if (o_fg_rgb !== want.fg_rgb)
                    report_mismatch($sformatf("ink RGB at line %0d column %0d: got %h, expected %h",
                                              want.line, want.column, o_fg_rgb, want.fg_rgb));
                if (o_bg_rgb !== want.bg_rgb)
                    report_mismatch($sformatf("paper RGB at line %0d column %0d: got %h, expected %h",
                                              want.line, want.column, o_bg_rgb, want.bg_rgb));
                if (o_last !== want.last)
                    report_mismatch($sformatf("last flag at line %0d column %0d: got %b, expected %b",
                                              want.line, want.column, o_last, want.last));
            end
        end
    end

    // Watchdog: any channel that moves a request, a result or a flash period resets the count.
    always @(posedge i_clk) begin
        int quiet_cycles;
        if ((i_valid && o_ready === 1'b1) || (o_valid === 1'b1 && i_ready)
                || (i_cfg_valid && o_cfg_ready === 1'b1)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no channel moved for %0d cycles", STALL_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // After the clearing pass the whole store reads as zero: corners of the
    // bitmap come back blank, black on black.
    task automatic test_power_up_contents();
        send_request(ACT_RENDER, VIDEO_BASE, 8'h00);
        send_request(ACT_RENDER, ATTR_BASE - 16'd1, 8'hFF);
    endtask

    // Single bitmap bytes at the first, last and a mid-screen position.
    task automatic test_bitmap_writes();
        send_request(ACT_WRITE, VIDEO_BASE, 8'hFF);
        send_request(ACT_WRITE, ATTR_BASE - 16'd1, 8'hA5);
        send_request(ACT_WRITE, bitmap_address(63, 0), 8'h3C);
        send_request(ACT_RENDER, bitmap_address(63, 0), 8'h00);
    endtask

    // Attribute writes redraw all eight rows of their cell: bright white ink,
    // plain paper, and every attribute bit set at the last cell.
    task automatic test_attribute_writes();
        send_request(ACT_WRITE, ATTR_BASE, 8'h47);
        send_request(ACT_WRITE, attribute_address(64, 16), 8'h38);
        send_request(ACT_WRITE, ATTR_END - 16'd1, 8'hFF);
    endtask

    // Flash inversion: a zero period toggles on every tick, a period of one
    // does too, and a longer period needs that many ticks before it toggles.
    task automatic test_flash_inversion();
        int n;
        send_request(ACT_WRITE, ATTR_END - 16'd1, 8'hC5);
        write_flash_period(6'd0);
        send_request(ACT_TICK, 16'h0000, 8'h00);
        send_request(ACT_RENDER, ATTR_BASE - 16'd1, 8'h00);
        send_request(ACT_TICK, 16'hFFFF, 8'hFF);
        send_request(ACT_RENDER, ATTR_BASE - 16'd1, 8'h00);
        write_flash_period(6'd1);
        send_request(ACT_TICK, 16'h0000, 8'h00);
        send_request(ACT_RENDER, ATTR_BASE - 16'd1, 8'h00);
        write_flash_period(6'd6);
        for (n = 0; n < 6; n++) begin
            send_request(ACT_TICK, 16'h0000, 8'h00);
        end
        send_request(ACT_RENDER, ATTR_BASE - 16'd1, 8'h00);
    endtask

    // Requests outside the screen, renders of attributes and the unused
    // action must change nothing; a render afterwards proves the store intact.
    task automatic test_ignored_requests();
        send_request(ACT_WRITE, 16'h0000, 8'hFF);
        send_request(ACT_WRITE, 16'hFFFF, 8'hFF);
        send_request(ACT_WRITE, VIDEO_BASE - 16'd1, 8'h5A);
        send_request(ACT_WRITE, ATTR_END, 8'h5A);
        send_request(ACT_RENDER, ATTR_BASE, 8'h00);
        send_request(ACT_RENDER, 16'hFFFF, 8'h00);
        send_request(ACT_NONE, VIDEO_BASE, 8'hFF);
        send_request(ACT_RENDER, VIDEO_BASE, 8'h00);
    endtask

    task automatic refresh_focus();
        int k;
        for (k = 0; k < 4; k++) begin
            focus_line[k] = $urandom_range(191);
            focus_col[k]  = $urandom_range(31);
        end
    endtask

    // One random request. Most of them land on the focus cells; about one in
    // ten is noise: any action on any address.
    task automatic send_random_request();
        int      pick;
        int      slot;
        int      line_no;
        int      col;
        t_action act;
        slot = $urandom_range(3);
        if ($urandom_range(99) < 70) begin
            line_no = focus_line[slot];
            col     = focus_col[slot];
        end else begin
            line_no = $urandom_range(191);
            col     = $urandom_range(31);
        end
        pick = $urandom_range(99);
        if (pick < 30) begin
            send_request(ACT_WRITE, bitmap_address(line_no, col), 8'($urandom));
        end else if (pick < 48) begin
            send_request(ACT_WRITE, attribute_address(line_no, col), 8'($urandom));
        end else if (pick < 70) begin
            send_request(ACT_RENDER, bitmap_address(line_no, col), 8'($urandom));
        end else if (pick < 86) begin
            send_request(ACT_TICK, 16'($urandom), 8'($urandom));
        end else if (pick < 90) begin
            send_request(ACT_RENDER, attribute_address(line_no, col), 8'($urandom));
        end else begin
            act = t_action'($urandom_range(3));
            send_request(act, 16'($urandom), 8'($urandom));
        end
    endtask

    // Four phases of random traffic, each with its own idle pattern and
    // flash period. Only requests that the block acts on are counted.
    task automatic test_random_traffic();
        int phase;
        int counted;
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    write_flash_period(6'd2);
                end
                1: begin
                    send_idle_pct  = 82;
                    recv_stall_pct = 0;
                    write_flash_period(FLASH_PERIOD_RST);
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 82;
                    write_flash_period(6'($urandom_range(1, 63)));
                end
                default: begin
                    send_idle_pct  = 14;
                    recv_stall_pct = 14;
                    write_flash_period(6'd1);
                end
            endcase
            refresh_focus();
            counted = 0;
            while (counted < 16) begin
                send_random_request();
                if (last_request_acted) counted++;
            end
        end
    endtask

    initial begin
        int k;
        for (k = 0; k < BMP_DEPTH + ATTR_DEPTH; k++) begin
            screen_mem[k] = 8'h00;
        end
        blink_count    = 6'd0;
        blink_inverted = 1'b0;
        blink_period   = FLASH_PERIOD_RST;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed checks run with both sides at full rate.
        test_power_up_contents();
        test_bitmap_writes();
        test_attribute_writes();
        test_flash_inversion();
        test_ignored_requests();
        test_random_traffic();

        settle_block();
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
